@@ sv/apob_pkg.sv @@
// Shared types, constants, tables and helper functions of the additive partial oscillator bank.
`default_nettype none

package apob_pkg;

    localparam int MUL_W        = 35;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int DIV_W        = 34;
    localparam int DEF_PARTIALS = 64;

    localparam logic [16:0] SMOOTH_ONE   = 17'd65536;
    localparam logic [16:0] ATTACK_FULL  = 17'd65536;
    localparam logic [47:0] ATTACK_KNEE  = 48'd10923;
    localparam logic [16:0] ATTACK_SLOPE = 17'd6;
    localparam logic [15:0] BLEND_WEIGHT = 16'd19661;
    localparam logic [23:0] DECAY_COEF   = 24'd9895605;
    localparam logic [14:0] TANH_SAT     = 15'd32746;

    localparam logic [1:0] CFG_TPS    = 2'd0;
    localparam logic [1:0] CFG_VEL    = 2'd1;
    localparam logic [1:0] CFG_SMOOTH = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SEED    = 2'd1,
        CMD_BLEND   = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SEED, ST_BL_RD, ST_BL_MUL, ST_BL_WR,
        ST_P, ST_Q, ST_TERM, ST_DSTART, ST_DWAIT, ST_ENV, ST_GAIN,
        ST_PSM, ST_PIL, ST_PIR, ST_PML, ST_PMR, ST_PAR,
        ST_XL, ST_XR, ST_TL, ST_TR, ST_TOUT, ST_EMIT
    } t_state;

    // One partial as held in the state memory.
    typedef struct packed {
        logic signed [15:0] tgt;
        logic signed [23:0] cur;
        logic [15:0]        pl;
        logic [15:0]        pr;
    } t_entry;

    // Operands of one table interpolation.
    typedef struct packed {
        logic [14:0] v0;
        logic [11:0] d;
        logic [15:0] f;
        logic        neg;
    } t_lerp;

    localparam logic [14:0] SINE_Q [0:64] = '{
        15'd0, 15'd804, 15'd1608, 15'd2411, 15'd3212, 15'd4011, 15'd4808, 15'd5602,
        15'd6393, 15'd7180, 15'd7962, 15'd8740, 15'd9512, 15'd10279, 15'd11039,
        15'd11793, 15'd12540, 15'd13279, 15'd14010, 15'd14733, 15'd15447, 15'd16151,
        15'd16846, 15'd17531, 15'd18205, 15'd18868, 15'd19520, 15'd20160, 15'd20788,
        15'd21403, 15'd22006, 15'd22595, 15'd23170, 15'd23732, 15'd24279, 15'd24812,
        15'd25330, 15'd25833, 15'd26320, 15'd26791, 15'd27246, 15'd27684, 15'd28106,
        15'd28511, 15'd28899, 15'd29269, 15'd29622, 15'd29957, 15'd30274, 15'd30572,
        15'd30853, 15'd31114, 15'd31357, 15'd31581, 15'd31786, 15'd31972, 15'd32138,
        15'd32286, 15'd32413, 15'd32522, 15'd32610, 15'd32679, 15'd32729, 15'd32758,
        15'd32767
    };

    localparam logic [14:0] TANH_Q [0:32] = '{
        15'd0, 15'd4075, 15'd8025, 15'd11743, 15'd15143, 15'd18173, 15'd20813,
        15'd23066, 15'd24956, 15'd26519, 15'd27796, 15'd28830, 15'd29660, 15'd30322,
        15'd30847, 15'd31262, 15'd31589, 15'd31846, 15'd32048, 15'd32206, 15'd32329,
        15'd32426, 15'd32500, 15'd32560, 15'd32606, 15'd32642, 15'd32670, 15'd32691,
        15'd32708, 15'd32722, 15'd32732, 15'd32740, 15'd32746
    };

    // Add half, then arithmetic shift right.
    function automatic logic signed [PROD_W-1:0] round_sh(
        input logic signed [PROD_W-1:0] v, input int n);
        return (v + (PROD_W'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic t_lerp sine_prep(input logic [31:0] ang);
        logic [22:0] pos;
        logic [6:0]  idx;
        logic [6:0]  nidx;
        t_lerp       l;
        pos = {1'b0, ang[29:8]};
        if (ang[30]) begin
            pos = 23'h400000 - pos;
        end
        idx   = pos[22:16];
        nidx  = (idx == 7'd64) ? idx : idx + 7'd1;
        l.v0  = SINE_Q[idx];
        l.d   = 12'(SINE_Q[nidx] - SINE_Q[idx]);
        l.f   = pos[15:0];
        l.neg = ang[31];
        return l;
    endfunction

    function automatic t_lerp tanh_prep(input logic signed [31:0] x);
        logic [31:0] mag;
        logic [5:0]  idx;
        t_lerp       l;
        mag   = x[31] ? 32'(-x) : 32'(x);
        idx   = {1'b0, mag[17:13]};
        l.neg = x[31];
        if (mag >= 32'h0004_0000) begin
            l.v0 = TANH_SAT;
            l.d  = '0;
            l.f  = '0;
        end else begin
            l.v0 = TANH_Q[idx];
            l.d  = 12'(TANH_Q[idx + 6'd1] - TANH_Q[idx]);
            l.f  = {3'b000, mag[12:0]};
        end
        return l;
    endfunction

    function automatic logic signed [15:0] lerp_out(input t_lerp l, input logic [15:0] add);
        logic [14:0] v;
        v = l.v0 + add[14:0];
        return l.neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

`default_nettype wire

@@ sv/apob_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none

module apob_mul
    import apob_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic signed [MUL_W-1:0]  i_a,
    input  wire logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]      o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ sv/apob_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module apob_div
    import apob_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic [DIV_W-1:0]      o_quot
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W:0]   w_sh;
    logic [DIV_W+1:0] w_diff;

    assign w_sh   = {r_rem, r_num[DIV_W-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[DIV_W-2:0], ~w_diff[DIV_W+1]};
            r_rem <= w_diff[DIV_W+1] ? w_sh[DIV_W-1:0] : w_diff[DIV_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_num;

endmodule

`default_nettype wire

@@ sv/apob_mem.sv @@
// Partial state memory with per-entry valid bits so that reset reads as zero.
`default_nettype none

module apob_mem
    import apob_pkg::*;
#(
    parameter int PARTIALS = DEF_PARTIALS,
    parameter int AW       = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data
);

    t_entry        r_mem [PARTIALS];
    t_entry        r_data;
    logic          r_hit;
    logic [PARTIALS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_hit ? r_data : '0;

endmodule

`default_nettype wire

@@ sv/additive_partial_oscillator_bank.sv @@
// Top level of the additive partial oscillator bank: sequencer, registers and datapath.
`default_nettype none

// Stereo additive oscillator bank for one voice. Items arrive on the slave stream with the
// command in tuser: a seed writes one partial's target and current amplitude and its two
// start phases, a blend pulls a partial's target 0.3 of the way from its current amplitude
// toward a new one, a restart zeroes the sample count, and a tick produces one stereo
// Q1.15 sample. A tick first works out the phase count and the attack and decay envelope,
// then walks every partial: it smooths the current amplitude toward the target, looks up
// both sines by table interpolation and accumulates amplitude times sine, and it finally
// applies gain and a tanh table. All multiplications go through one shared 35 by 35 bit
// multiplier, one product per cycle, and a bit-serial divider forms the decay term. The
// input is not ready while an item is at work. Results sit in an output register, so the
// next item is taken while a sample still waits; a tick waits at its end only if the
// previous sample has not been transferred yet. Configuration writes are taken in every
// cycle.
module additive_partial_oscillator_bank
    import apob_pkg::*;
#(
    parameter int PARTIALS = DEF_PARTIALS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [5:0] partial_index, [21:6] amplitude, [37:22] phase_left, [53:38] phase_right
    input  wire logic [55:0] i_s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]  i_s_axis_tuser,
    // Output stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] sample_left, [31:16] sample_right
    output logic [31:0]      o_m_axis_tdata,
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;

    // Sequencer state.
    t_state r_state;
    t_state n_state;

    // Latched item fields.
    logic [5:0]         r_idx;
    logic signed [15:0] r_amp;
    logic [15:0]        r_pl;
    logic [15:0]        r_pr;

    // Configuration registers and the sample count.
    logic [31:0] r_tps;
    logic [15:0] r_vel;
    logic [16:0] r_smooth;
    logic [31:0] r_count;

    // Tick datapath.
    logic [63:0]        r_p;
    logic [16:0]        r_g;
    logic [AW-1:0]      r_k;
    logic [31:0]        r_base;
    t_entry             r_ent;
    logic signed [23:0] r_cur;
    t_lerp              r_ll;
    t_lerp              r_lr;
    t_lerp              r_lt;
    logic signed [15:0] r_sin_l;
    logic signed [15:0] r_sin_r;
    logic signed [47:0] r_acc_l;
    logic signed [47:0] r_acc_r;
    logic signed [31:0] r_x;
    logic signed [15:0] r_out_l;
    logic signed [15:0] r_out_r;
    logic               r_m_valid;
    logic [31:0]        r_m_data;

    // Shared units.
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic                     w_rd_en;
    logic [AW-1:0]            w_rd_addr;
    t_entry                   w_rd_data;
    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    t_entry                   w_wr_data;
    logic                     w_div_start;
    logic                     w_div_busy;
    logic [DIV_W-1:0]         w_dividend;
    logic [DIV_W-1:0]         w_divisor;
    logic [DIV_W-1:0]         w_quot;

    // Combinational values.
    logic               w_s_fire;
    t_cmd               w_cmd;
    logic               w_in_range;
    logic               w_last;
    logic               w_slot_free;
    logic [39:0]        w_qfull;
    logic [24:0]        w_q;
    logic [32:0]        w_denom;
    logic [16:0]        w_attack;
    logic [16:0]        w_decay;
    logic [16:0]        w_env;
    logic [16:0]        w_seff;
    logic signed [25:0] w_diff_s;
    logic signed [25:0] w_diff_b;
    logic signed [23:0] w_cur_new;
    logic signed [26:0] w_bl_t;
    logic signed [18:0] w_bl_r;
    logic signed [15:0] w_bl_q;
    logic signed [MUL_W-1:0] w_s15_l;
    logic signed [MUL_W-1:0] w_s15_r;
    logic signed [31:0] w_x_new;
    t_lerp              w_tp;

    assign w_s_fire    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd       = t_cmd'(i_s_axis_tuser);
    assign w_in_range  = (9'(r_idx) < 9'(PARTIALS));
    assign w_last      = (r_k == AW'(PARTIALS - 1));
    assign w_slot_free = !r_m_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    apob_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    apob_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    apob_mem #(
        .PARTIALS (PARTIALS),
        .AW       (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // Datapath values that the states below pick from.
    always_comb begin
        // Decay: q = min(P >> 24, 2^24), the divider forms round(2^32 / (65536 + term)).
        w_qfull    = w_prod[63:24];
        w_q        = (w_qfull > 40'h100_0000) ? 25'h100_0000 : w_qfull[24:0];
        w_denom    = 33'(w_prod[55:24]) + 33'd65536;
        w_divisor  = DIV_W'(w_denom);
        w_dividend = DIV_W'(34'h1_0000_0000) + DIV_W'(w_denom >> 1);
        w_decay    = w_quot[16:0];
        // Attack rises linearly with P >> 16 until it reaches one.
        w_attack   = (r_p[63:16] >= ATTACK_KNEE) ? ATTACK_FULL
                                                 : 17'(r_p[29:16]) * ATTACK_SLOPE;
        w_env      = (w_attack < w_decay) ? w_attack : w_decay;
        w_seff     = (r_smooth > SMOOTH_ONE) ? SMOOTH_ONE : r_smooth;
        // Amplitude steps.
        w_diff_s   = 26'($signed({w_rd_data.tgt, 8'h00})) - 26'(w_rd_data.cur);
        w_diff_b   = 26'($signed({r_amp, 8'h00})) - 26'(w_rd_data.cur);
        w_cur_new  = 24'(27'(r_ent.cur) + 27'(round_sh(w_prod, 16)));
        w_bl_t     = 27'(r_ent.cur) + 27'(round_sh(w_prod, 16));
        w_bl_r     = 19'((w_bl_t + 27'sd128) >>> 8);
        if (w_bl_r > 19'sd32767) begin
            w_bl_q = 16'sh7FFF;
        end else if (w_bl_r < -19'sd32768) begin
            w_bl_q = -16'sh8000;
        end else begin
            w_bl_q = 16'(w_bl_r);
        end
        // Output scaling and tanh.
        w_s15_l = MUL_W'(round_sh(PROD_W'(r_acc_l), 15));
        w_s15_r = MUL_W'(round_sh(PROD_W'(r_acc_r), 15));
        w_x_new = 32'(round_sh(w_prod, 23));
        w_tp    = tanh_prep(r_x);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_s_fire) begin
                    case (w_cmd)
                        CMD_TICK:  n_state = ST_P;
                        CMD_SEED:  n_state = ST_SEED;
                        CMD_BLEND: n_state = ST_BL_RD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SEED:   n_state = ST_IDLE;
            ST_BL_RD:  n_state = w_in_range ? ST_BL_MUL : ST_IDLE;
            ST_BL_MUL: n_state = ST_BL_WR;
            ST_BL_WR:  n_state = ST_IDLE;
            ST_P:      n_state = ST_Q;
            ST_Q:      n_state = ST_TERM;
            ST_TERM:   n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DWAIT;
            ST_DWAIT:  n_state = w_div_busy ? ST_DWAIT : ST_ENV;
            ST_ENV:    n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_PSM;
            ST_PSM:    n_state = ST_PIL;
            ST_PIL:    n_state = ST_PIR;
            ST_PIR:    n_state = ST_PML;
            ST_PML:    n_state = ST_PMR;
            ST_PMR:    n_state = ST_PAR;
            ST_PAR:    n_state = w_last ? ST_XL : ST_PSM;
            ST_XL:     n_state = ST_XR;
            ST_XR:     n_state = ST_TL;
            ST_TL:     n_state = ST_TR;
            ST_TR:     n_state = ST_TOUT;
            ST_TOUT:   n_state = ST_EMIT;
            ST_EMIT:   n_state = w_slot_free ? ST_IDLE : ST_EMIT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control of the shared multiplier, the memory and the divider.
    always_comb begin
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_k;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_k;
        w_wr_data   = r_ent;
        w_div_start = 1'b0;
        case (r_state)
            ST_SEED: begin
                w_wr_en   = w_in_range;
                w_wr_addr = AW'(r_idx);
                w_wr_data = '{tgt: r_amp, cur: $signed({r_amp, 8'h00}), pl: r_pl, pr: r_pr};
            end
            ST_BL_RD: begin
                w_rd_en   = w_in_range;
                w_rd_addr = AW'(r_idx);
            end
            ST_BL_MUL: begin
                w_mul_a = MUL_W'(w_diff_b);
                w_mul_b = MUL_W'(BLEND_WEIGHT);
            end
            ST_BL_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = AW'(r_idx);
                w_wr_data = '{tgt: w_bl_q, cur: r_ent.cur, pl: r_ent.pl, pr: r_ent.pr};
            end
            ST_P: begin
                w_mul_a = MUL_W'(r_count);
                w_mul_b = MUL_W'(r_tps);
            end
            ST_Q: begin
                w_mul_a = MUL_W'(w_q);
                w_mul_b = MUL_W'(w_q);
            end
            ST_TERM: begin
                w_mul_a = MUL_W'(w_prod[48:16]);
                w_mul_b = MUL_W'(DECAY_COEF);
            end
            ST_DSTART: begin
                w_div_start = 1'b1;
            end
            ST_ENV: begin
                w_mul_a = MUL_W'(w_env);
                w_mul_b = MUL_W'(r_vel);
            end
            ST_GAIN: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
            end
            ST_PSM: begin
                w_mul_a = MUL_W'(w_diff_s);
                w_mul_b = MUL_W'(w_seff);
            end
            ST_PIL: begin
                w_wr_en   = 1'b1;
                w_wr_data = '{tgt: r_ent.tgt, cur: w_cur_new, pl: r_ent.pl, pr: r_ent.pr};
                w_mul_a   = MUL_W'(r_ll.d);
                w_mul_b   = MUL_W'(r_ll.f);
            end
            ST_PIR: begin
                w_mul_a = MUL_W'(r_lr.d);
                w_mul_b = MUL_W'(r_lr.f);
            end
            ST_PML: begin
                w_mul_a = MUL_W'(r_cur);
                w_mul_b = MUL_W'(r_sin_l);
            end
            ST_PMR: begin
                w_mul_a = MUL_W'(r_cur);
                w_mul_b = MUL_W'(r_sin_r);
            end
            ST_PAR: begin
                w_rd_en   = !w_last;
                w_rd_addr = r_k + AW'(1);
            end
            ST_XL: begin
                w_mul_a = w_s15_l;
                w_mul_b = MUL_W'(r_g);
            end
            ST_XR: begin
                w_mul_a = w_s15_r;
                w_mul_b = MUL_W'(r_g);
            end
            ST_TL, ST_TR: begin
                w_mul_a = MUL_W'(w_tp.d);
                w_mul_b = MUL_W'(w_tp.f);
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tps     <= '0;
            r_vel     <= 16'd32768;
            r_smooth  <= 17'd164;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TPS:    r_tps    <= i_cfg_data;
                    CFG_VEL:    r_vel    <= i_cfg_data[15:0];
                    CFG_SMOOTH: r_smooth <= i_cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
            if (w_s_fire && (w_cmd == CMD_RESTART)) begin
                r_count <= '0;
            end else if ((r_state == ST_EMIT) && w_slot_free && (r_count != '1)) begin
                // The count sticks at its maximum.
                r_count <= r_count + 32'd1;
            end
            if ((r_state == ST_EMIT) && w_slot_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_s_fire) begin
                    r_idx <= i_s_axis_tdata[5:0];
                    r_amp <= $signed(i_s_axis_tdata[21:6]);
                    r_pl  <= i_s_axis_tdata[37:22];
                    r_pr  <= i_s_axis_tdata[53:38];
                end
            end
            ST_BL_MUL: r_ent <= w_rd_data;
            ST_Q:      r_p   <= w_prod[63:0];
            ST_GAIN: begin
                r_g     <= w_prod[32:16];
                r_k     <= '0;
                r_base  <= r_p[31:0];
                r_acc_l <= '0;
                r_acc_r <= '0;
            end
            ST_PSM: begin
                // The angle of partial k steps by the base phase increment per partial.
                r_ent <= w_rd_data;
                r_ll  <= sine_prep(r_base + {w_rd_data.pl, 16'h0000});
                r_lr  <= sine_prep(r_base + {w_rd_data.pr, 16'h0000});
            end
            ST_PIL: r_cur   <= w_cur_new;
            ST_PIR: r_sin_l <= lerp_out(r_ll, w_prod[31:16]);
            ST_PML: r_sin_r <= lerp_out(r_lr, w_prod[31:16]);
            ST_PMR: r_acc_l <= r_acc_l + 48'(w_prod);
            ST_PAR: begin
                r_acc_r <= r_acc_r + 48'(w_prod);
                r_k     <= r_k + AW'(1);
                r_base  <= r_base + r_p[31:0];
            end
            ST_XR: r_x <= w_x_new;
            ST_TL: begin
                r_lt <= w_tp;
                r_x  <= w_x_new;
            end
            ST_TR: begin
                r_out_l <= lerp_out(r_lt, w_prod[28:13]);
                r_lt    <= w_tp;
            end
            ST_TOUT: r_out_r <= lerp_out(r_lt, w_prod[28:13]);
            ST_EMIT: begin
                if (w_slot_free) begin
                    r_m_data <= {r_out_r, r_out_l};
                end
            end
            default: begin
            end
        endcase
    end

    // A tick transfer closes the input.
    a_tick_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && (w_cmd == CMD_TICK)) |=> !o_s_axis_tready)
        else $error("input open right after a tick transfer");

    // The envelope must only use a finished quotient.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ENV) |-> !w_div_busy)
        else $error("envelope read while divider busy");

    // A new sample appears only from the emit step.
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == ST_EMIT))
        else $error("output valid rose outside emit");

    // Each emitted sample advances the count unless it is saturated.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && w_slot_free && (r_count != '1))
        |=> (r_count == $past(r_count) + 32'd1))
        else $error("sample count did not advance");

    // The state memory never sees a read and a write in the same cycle.
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !w_rd_en)
        else $error("memory read and write collide");

endmodule

`default_nettype wire
